>>> design/mpba_pkg.sv
// Shared constants, codes and types of the multi-pool block allocator.
`default_nettype none

package mpba_pkg;

  localparam int N_POOLS         = 4;
  localparam int BLOCKS_PER_POOL = 64;

  localparam int POOL_W  = $clog2(N_POOLS);
  localparam int BLK_W   = $clog2(BLOCKS_PER_POOL);
  localparam int USED_W  = $clog2(BLOCKS_PER_POOL + 1);
  localparam int SIZE_W  = 16;
  localparam int CNT_W   = 7;

  // Configuration register map
  localparam int NUM_REGS          = 2 * N_POOLS;
  localparam int CFG_IDX_W         = 4;
  localparam int CFG_DATA_W        = 16;
  localparam int REG_BLOCK_SIZE_0  = 0;
  localparam int REG_BLOCK_COUNT_0 = N_POOLS;

  localparam logic [SIZE_W-1:0] BSIZE_RESET = SIZE_W'(64);

  // Stream packing
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_BLOCK   = 2'd1,
    ST_BAD_HANDLE = 2'd2,
    ST_ZERO_SIZE  = 2'd3
  } status_e;

  typedef struct packed {
    logic             rebuild;
    logic             pop;
    logic             push;
    logic [BLK_W-1:0] blk;
  } pool_cmd_t;

  typedef struct packed {
    logic [BLK_W-1:0]  head;
    logic [USED_W-1:0] used;
    logic              busy;
  } pool_stat_t;

endpackage

`default_nettype wire

>>> design/mpba_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module mpba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> design/mpba_pool.sv
// One pool: free-block stack with head register, prefetched next entry and busy flags.
`default_nettype none

module mpba_pool (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire mpba_pkg::pool_cmd_t cmd_i,
  output mpba_pkg::pool_stat_t    stat_o
);

  localparam int BPP    = mpba_pkg::BLOCKS_PER_POOL;
  localparam int BLK_W  = mpba_pkg::BLK_W;
  localparam int USED_W = mpba_pkg::USED_W;

  // Stack position used_q holds the head; position used_q+1 is prefetched.
  logic [BLK_W-1:0]  head_q, head_d;
  logic [USED_W-1:0] used_q, used_d;
  logic [BPP-1:0]    busy_q, busy_d;
  logic [BPP-1:0]    vld_q, vld_d;
  logic              byp_q, byp_d;
  logic [BLK_W-1:0]  byp_data_q, byp_data_d;
  logic [BLK_W-1:0]  raddr_q, raddr_d;

  logic              wr;
  logic [BLK_W-1:0]  waddr;
  logic [BLK_W-1:0]  rdata;
  logic [BLK_W-1:0]  nxt;
  logic [USED_W-1:0] used_inc;

  // Never-written stack entries hold their own position.
  assign nxt = byp_q ? byp_data_q : (vld_q[raddr_q] ? rdata : raddr_q);

  assign wr    = cmd_i.push && !cmd_i.rebuild && (used_q < USED_W'(BPP));
  assign waddr = used_q[BLK_W-1:0];

  always_comb begin
    used_d     = used_q;
    head_d     = head_q;
    busy_d     = busy_q;
    vld_d      = vld_q;
    byp_data_d = head_q;
    if (cmd_i.rebuild) begin
      used_d     = '0;
      head_d     = '0;
      busy_d     = '0;
      vld_d      = '0;
      byp_data_d = BLK_W'(1);
    end else if (cmd_i.pop) begin
      used_d         = used_q + USED_W'(1);
      head_d         = nxt;
      busy_d[head_q] = 1'b1;
    end else if (cmd_i.push) begin
      used_d            = used_q - USED_W'(1);
      head_d            = cmd_i.blk;
      busy_d[cmd_i.blk] = 1'b0;
      if (wr) begin
        vld_d[waddr] = 1'b1;
      end
    end
    used_inc = used_d + USED_W'(1);
    raddr_d  = used_inc[BLK_W-1:0];
    // Forward the entry being written when it is the one to prefetch, or position 1 after a rebuild
    byp_d    = cmd_i.rebuild || (wr && (waddr == raddr_d));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q     <= '0;
      head_q     <= '0;
      busy_q     <= '0;
      vld_q      <= '0;
      byp_q      <= 1'b1;
      byp_data_q <= BLK_W'(1);
      raddr_q    <= BLK_W'(1);
    end else begin
      used_q     <= used_d;
      head_q     <= head_d;
      busy_q     <= busy_d;
      vld_q      <= vld_d;
      byp_q      <= byp_d;
      byp_data_q <= byp_data_d;
      raddr_q    <= raddr_d;
    end
  end

  mpba_ram #(
    .WIDTH (BLK_W),
    .DEPTH (BPP)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (wr),
    .waddr_i (waddr),
    .wdata_i (head_q),
    .raddr_i (raddr_d),
    .rdata_o (rdata)
  );

  assign stat_o.head = head_q;
  assign stat_o.used = used_q;
  assign stat_o.busy = busy_q[cmd_i.blk];

endmodule

`default_nettype wire

>>> design/multi_pool_block_allocator.sv
// An input transfer passes the input register and then the result register on its way to the master side.
// Throughput: one request per cycle unless the result side stalls; each pool's next free
// block is prefetched from its stack RAM, so back-to-back pops of one pool do not stall.
// When empty, the input register accepts while a finished result still waits downstream.
// Reset (rst_ni low, asynchronous): pools empty and absent, block sizes 64,
// all free lists rebuilt; no clearing pass, requests are taken at once.
`default_nettype none

module multi_pool_block_allocator (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [mpba_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [mpba_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Requests
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: size[15:0], free_pool[17:16], block_index[23:18]
  input  wire logic [mpba_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // tuser: op[0]
  input  wire logic                                s_axis_tuser,
  // Results
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // tdata: status[1:0], granted_pool[3:2], granted_block[9:4], pool_used[16:10], zero
  output logic [mpba_pkg::OUT_DATA_W-1:0]          m_axis_tdata
);

  localparam int NP        = mpba_pkg::N_POOLS;
  localparam int BPP       = mpba_pkg::BLOCKS_PER_POOL;
  localparam int POOL_W    = mpba_pkg::POOL_W;
  localparam int BLK_W     = mpba_pkg::BLK_W;
  localparam int USED_W    = mpba_pkg::USED_W;
  localparam int SIZE_W    = mpba_pkg::SIZE_W;
  localparam int CNT_W     = mpba_pkg::CNT_W;
  localparam int CFG_IDX_W = mpba_pkg::CFG_IDX_W;

  // Configuration registers
  logic [SIZE_W-1:0] bsize_q [NP];
  logic [CNT_W-1:0]  cnt_q   [NP];
  logic              cfg_hit;
  logic              cfg_is_cnt;
  logic [POOL_W-1:0] cfg_pool;

  assign cfg_hit    = cfg_we_i && (cfg_idx_i < CFG_IDX_W'(mpba_pkg::NUM_REGS));
  assign cfg_is_cnt = cfg_idx_i >= CFG_IDX_W'(mpba_pkg::REG_BLOCK_COUNT_0);
  assign cfg_pool   = cfg_idx_i[POOL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NP; p++) begin
        bsize_q[p] <= mpba_pkg::BSIZE_RESET;
        cnt_q[p]   <= '0;
      end
    end else if (cfg_hit) begin
      if (cfg_is_cnt) begin
        cnt_q[cfg_pool] <= cfg_data_i[CNT_W-1:0];
      end else begin
        bsize_q[cfg_pool] <= cfg_data_i[SIZE_W-1:0];
      end
    end
  end

  // Input register
  logic                 in_valid_q;
  mpba_pkg::op_e        in_op_q;
  logic [SIZE_W-1:0]    in_size_q;
  logic [POOL_W-1:0]    in_pool_q;
  logic [BLK_W-1:0]     in_blk_q;
  logic                 advance;

  assign advance       = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op_q   <= mpba_pkg::op_e'(s_axis_tuser);
      in_size_q <= s_axis_tdata[15:0];
      in_pool_q <= s_axis_tdata[17:16];
      in_blk_q  <= s_axis_tdata[23:18];
    end
  end

  // Pools
  mpba_pkg::pool_cmd_t  cmd  [NP];
  mpba_pkg::pool_stat_t stat [NP];
  logic [USED_W-1:0]    cnt_eff [NP];
  logic [NP-1:0]        fit;

  for (genvar g = 0; g < NP; g++) begin : g_pool
    mpba_pool u_pool (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd[g]),
      .stat_o (stat[g])
    );
  end

  logic                 sel_found;
  logic [POOL_W-1:0]    sel_pool;
  logic                 is_alloc;
  logic                 size_zero;
  logic                 free_ok;
  mpba_pkg::pool_stat_t fstat;
  mpba_pkg::pool_stat_t astat;

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      cnt_eff[p] = (cnt_q[p] > CNT_W'(BPP)) ? USED_W'(BPP) : USED_W'(cnt_q[p]);
      fit[p]     = (stat[p].used < cnt_eff[p]) && (in_size_q <= bsize_q[p]);
    end
    // Lowest-numbered pool that fits wins
    sel_found = 1'b0;
    sel_pool  = '0;
    for (int p = NP - 1; p >= 0; p--) begin
      if (fit[p]) begin
        sel_found = 1'b1;
        sel_pool  = POOL_W'(p);
      end
    end
    is_alloc  = (in_op_q == mpba_pkg::OP_ALLOC);
    size_zero = (in_size_q == '0);
    fstat     = stat[in_pool_q];
    astat     = stat[sel_pool];
    free_ok   = (USED_W'(in_blk_q) < cnt_eff[in_pool_q]) && fstat.busy;
    for (int p = 0; p < NP; p++) begin
      cmd[p].rebuild = cfg_hit && (cfg_pool == POOL_W'(p));
      cmd[p].pop     = advance && is_alloc && !size_zero && sel_found
                       && (sel_pool == POOL_W'(p));
      cmd[p].push    = advance && !is_alloc && free_ok && (in_pool_q == POOL_W'(p));
      cmd[p].blk     = in_blk_q;
    end
  end

  // Result register
  mpba_pkg::status_e res_status;
  logic [POOL_W-1:0] res_pool;
  logic [BLK_W-1:0]  res_blk;
  logic [USED_W-1:0] res_used;

  always_comb begin
    res_status = mpba_pkg::ST_OK;
    res_pool   = '0;
    res_blk    = '0;
    res_used   = '0;
    if (is_alloc) begin
      if (size_zero) begin
        res_status = mpba_pkg::ST_ZERO_SIZE;
      end else if (!sel_found) begin
        res_status = mpba_pkg::ST_NO_BLOCK;
      end else begin
        res_pool = sel_pool;
        res_blk  = astat.head;
        res_used = astat.used + USED_W'(1);
      end
    end else begin
      res_pool = in_pool_q;
      res_blk  = in_blk_q;
      if (free_ok) begin
        res_used = fstat.used - USED_W'(1);
      end else begin
        res_status = mpba_pkg::ST_BAD_HANDLE;
        res_used   = fstat.used;
      end
    end
  end

  logic [1:0]        out_status_q;
  logic [POOL_W-1:0] out_pool_q;
  logic [BLK_W-1:0]  out_blk_q;
  logic [USED_W-1:0] out_used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_status_q <= res_status;
      out_pool_q   <= res_pool;
      out_blk_q    <= res_blk;
      out_used_q   <= res_used;
    end
  end

  assign m_axis_tdata = {7'd0, out_used_q, out_blk_q, out_pool_q, out_status_q};

endmodule

`default_nettype wire

>>> design/mpba_checker.sv
// Port-level checks of the multi-pool block allocator, bound to the top level.
`default_nettype none

module mpba_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [mpba_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  logic [1:0] st;
  assign st = m_axis_tdata[1:0];

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Request side only backs up when the result side is stalled
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a stalled result");

  // Failed allocations carry no handle
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == mpba_pkg::ST_NO_BLOCK || st == mpba_pkg::ST_ZERO_SIZE)
    |-> m_axis_tdata[23:2] == '0)
    else $error("failed allocation carries a handle");

  // Busy count never exceeds a pool
  a_used_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[16:10] <= 7'(mpba_pkg::BLOCKS_PER_POOL))
    else $error("pool_used out of range");

endmodule

bind multi_pool_block_allocator mpba_checker u_mpba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
